### design/sktab_pkg.sv
// Shared types and constants for the sorted key/child table.
`default_nettype none

package sktab_pkg;

  localparam int KEY_BITS   = 8;
  localparam int CHILD_W    = 64;
  localparam int COUNT_BITS = 5;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  // Command broadcast to every cell in the row.
  typedef struct packed {
    logic                ins;
    logic [KEY_BITS-1:0] key;
  } cmd_t;

  // Control status that one cell hands to the next one up the row.
  typedef struct packed {
    logic valid;
    logic moves;
    logic hit;
  } link_t;

endpackage

`default_nettype wire

### design/sktab_if.sv
// Handshake channel interfaces for the request and result items.
`default_nettype none

interface sktab_in_if;
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic [sktab_pkg::KEY_BITS-1:0] key;
  logic [sktab_pkg::CHILD_W-1:0]  child;

  modport source (output valid, kind, key, child, input ready);
  modport sink   (input valid, kind, key, child, output ready);
endinterface

interface sktab_out_if;
  logic                             valid;
  logic                             ready;
  logic                             found;
  logic [sktab_pkg::CHILD_W-1:0]    child_out;
  logic                             inserted;
  logic                             full_res;
  logic [sktab_pkg::COUNT_BITS-1:0] entry_count;

  modport source (output valid, found, child_out, inserted, full_res, entry_count,
                  input ready);
  modport sink   (input valid, found, child_out, inserted, full_res, entry_count,
                  output ready);
endinterface

`default_nettype wire

### design/sorted_key_child_table.sv
// Top level of the sorted key/child table built as a row of cells.
//
// The table keeps up to ENTRIES byte keys with their child words in
// ascending unsigned key order, as the sixteen-way node of a radix tree
// does. Each request item is either an insert (kind 0) or a lookup
// (kind 1) and yields exactly one result item. An insert places the pair
// after any equal keys; every slot decides on its own whether to keep its
// pair, take its lower neighbor's pair or take the new pair, so the whole
// shift happens on the clock edge that accepts the item. An insert
// into a full table changes nothing and reports full_res. A lookup returns
// the child of the lowest matching slot, or found low with a zero child.
// entry_count always reports the number of entries after the item, taken
// modulo 32. The block takes one item per clock: the result is registered
// and shows on the output channel in the cycle after acceptance, and a new
// item is taken in the same cycle that the pending result is taken, so
// in_ch.ready only drops while a result waits on a stalled output. The
// per-item path is one key compare in each cell followed by the slot
// decision for an insert, or by an OR tree over the cells for a lookup.
// Stored children keep only the low CHILD_BITS bits of the child field.
`default_nettype none

module sorted_key_child_table #(
  parameter int ENTRIES    = 16,
  parameter int CHILD_BITS = 64
) (
  input  wire          clk,
  input  wire          rst_n,
  sktab_in_if.sink     in_ch,
  sktab_out_if.source  out_ch
);

  localparam int CntW     = $clog2(ENTRIES + 1);
  localparam int CntOutW  = sktab_pkg::COUNT_BITS;
  localparam int ChildOut = sktab_pkg::CHILD_W;

  sktab_pkg::link_t                     link      [ENTRIES];
  sktab_pkg::link_t                     prev_link [ENTRIES];
  logic [sktab_pkg::KEY_BITS-1:0]       key_q     [ENTRIES];
  logic [sktab_pkg::KEY_BITS-1:0]       prev_key  [ENTRIES];
  logic [CHILD_BITS-1:0]                child_q   [ENTRIES];
  logic [CHILD_BITS-1:0]                prev_child[ENTRIES];
  logic [CHILD_BITS-1:0]                hit_child [ENTRIES];

  sktab_pkg::cmd_t       cmd;
  logic [CHILD_BITS-1:0] new_child;
  logic                  accept;
  logic                  is_insert;
  logic                  table_full;
  logic [CHILD_BITS-1:0] lookup_child;
  logic                  lookup_found;

  logic [CntW-1:0]       count_r;
  logic [CntW-1:0]       count_nxt;

  logic                  out_valid_r;
  logic                  found_r;
  logic [ChildOut-1:0]   child_out_r;
  logic                  inserted_r;
  logic                  full_res_r;
  logic [CntOutW-1:0]    entry_count_r;

  // A new item enters whenever the output register is empty or being drained.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_insert   = (in_ch.kind == sktab_pkg::KIND_INSERT);

  // Entries fill from the bottom, so the table is full exactly when the top
  // slot is occupied.
  assign table_full = link[ENTRIES-1].valid;

  assign cmd.ins   = accept && is_insert && !table_full;
  assign cmd.key   = in_ch.key;
  assign new_child = in_ch.child[CHILD_BITS-1:0];

  // The bottom cell sees an occupied, non-moving, non-matching neighbor.
  always_comb begin
    prev_link[0].valid = 1'b1;
    prev_link[0].moves = 1'b0;
    prev_link[0].hit   = 1'b0;
    prev_key[0]        = in_ch.key;
    prev_child[0]      = new_child;
    for (int i = 1; i < ENTRIES; i++) begin
      prev_link[i]  = link[i-1];
      prev_key[i]   = key_q[i-1];
      prev_child[i] = child_q[i-1];
    end
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    sktab_cell #(
      .CHILD_BITS (CHILD_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .new_child  (new_child),
      .prev_link  (prev_link[g]),
      .prev_key   (prev_key[g]),
      .prev_child (prev_child[g]),
      .link       (link[g]),
      .key_o      (key_q[g]),
      .child_o    (child_q[g]),
      .hit_child  (hit_child[g])
    );
  end

  // At most one cell drives a nonzero child, so an OR across the row selects it.
  always_comb begin
    lookup_child = '0;
    lookup_found = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      lookup_child = lookup_child | hit_child[i];
      lookup_found = lookup_found | link[i].hit;
    end
  end

  assign count_nxt = cmd.ins ? count_r + CntW'(1) : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (accept) begin
      found_r       <= !is_insert && lookup_found;
      child_out_r   <= is_insert ? '0 : ChildOut'(lookup_child);
      inserted_r    <= is_insert && !table_full;
      full_res_r    <= is_insert && table_full;
      entry_count_r <= CntOutW'(count_nxt);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.found       = found_r;
  assign out_ch.child_out   = child_out_r;
  assign out_ch.inserted    = inserted_r;
  assign out_ch.full_res    = full_res_r;
  assign out_ch.entry_count = entry_count_r;

endmodule

`default_nettype wire

### design/sktab_cell.sv
// One table slot: holds a key/child pair and shifts it up the row on insert.
`default_nettype none

module sktab_cell #(
  parameter int CHILD_BITS = 64
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire sktab_pkg::cmd_t                cmd,
  input  wire [CHILD_BITS-1:0]                new_child,
  input  wire sktab_pkg::link_t               prev_link,
  input  wire [sktab_pkg::KEY_BITS-1:0]       prev_key,
  input  wire [CHILD_BITS-1:0]                prev_child,
  output sktab_pkg::link_t                    link,
  output logic [sktab_pkg::KEY_BITS-1:0]      key_o,
  output logic [CHILD_BITS-1:0]               child_o,
  output logic [CHILD_BITS-1:0]               hit_child
);

  logic                          valid_r;
  logic                          valid_nxt;
  logic [sktab_pkg::KEY_BITS-1:0] key_r;
  logic [sktab_pkg::KEY_BITS-1:0] key_nxt;
  logic [CHILD_BITS-1:0]          child_r;
  logic [CHILD_BITS-1:0]          child_nxt;
  logic                          moves;
  logic                          hit;
  logic                          take_new;

  assign moves = valid_r && (key_r > cmd.key);
  assign hit   = valid_r && (key_r == cmd.key);

  // The new pair lands in the first slot that is either moving up or empty,
  // provided the slot below it is occupied and staying put.
  assign take_new = (moves || !valid_r) && !prev_link.moves && prev_link.valid;

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    child_nxt = child_r;
    if (cmd.ins) begin
      if (prev_link.moves) begin
        valid_nxt = 1'b1;
        key_nxt   = prev_key;
        child_nxt = prev_child;
      end else if (take_new) begin
        valid_nxt = 1'b1;
        key_nxt   = cmd.key;
        child_nxt = new_child;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    key_r   <= key_nxt;
    child_r <= child_nxt;
  end

  assign link.valid = valid_r;
  assign link.moves = moves;
  assign link.hit   = hit;
  assign key_o      = key_r;
  assign child_o    = child_r;

  // Keys are sorted, so matches are contiguous; the first one is the lowest.
  assign hit_child = (hit && !prev_link.hit) ? child_r : '0;

endmodule

`default_nettype wire

### design/sktab_checker.sv
// Port-level checks for the sorted key/child table, bound to the top level.
`default_nettype none

module sktab_checker (
  input wire                                  clk,
  input wire                                  rst_n,
  input wire                                  in_valid,
  input wire                                  in_ready,
  input wire                                  out_valid,
  input wire                                  out_ready,
  input wire                                  found,
  input wire [sktab_pkg::CHILD_W-1:0]         child_out,
  input wire                                  inserted,
  input wire                                  full_res,
  input wire [sktab_pkg::COUNT_BITS-1:0]      entry_count
);

  // Every accepted item shows its result in the following cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item produced no result");

  // A performed insert leaves at least one entry and reports nothing else.
  a_insert_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && inserted |-> !full_res && !found && entry_count != '0)
    else $error("insert result fields inconsistent");

  // A miss or any insert result carries a zero child.
  a_zero_child: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !found |-> child_out == '0)
    else $error("child nonzero without a match");

  // A stalled result stays valid and holds its child and entry count.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(child_out) && $stable(entry_count))
    else $error("stalled result changed");

endmodule

bind sorted_key_child_table sktab_checker u_sktab_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .found       (out_ch.found),
  .child_out   (out_ch.child_out),
  .inserted    (out_ch.inserted),
  .full_res    (out_ch.full_res),
  .entry_count (out_ch.entry_count)
);

`default_nettype wire
